/* hdl/pdrg_pkg.sv */
package pdrg_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int TARGET_WIDTH    = 32;
    localparam int GRAD_WIDTH      = 32;
    localparam int GRAD_FRAC       = 30;
    localparam int QUO_BITS        = GRAD_FRAC + 2;
    localparam int STATUS_WIDTH    = 2;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_COINCIDENT = 2'd1,
        STATUS_MISSING    = 2'd2
    } status_t;

    typedef struct packed {
        logic [TARGET_WIDTH-1:0] residual;
        logic [GRAD_WIDTH-1:0]   grad_first_x;
        logic [GRAD_WIDTH-1:0]   grad_first_y;
        logic [GRAD_WIDTH-1:0]   grad_second_x;
        logic [GRAD_WIDTH-1:0]   grad_second_y;
        status_t                 status;
    } result_t;

endpackage

/* hdl/point_distance_residual_gradient.sv */
// Distance constraint residual and gradient.
// s_axis: one constraint per word; s_axis_tuser carries points_present.
// m_axis: one result per word, in input order.
// The datapath is a single pipeline with one valid bit per stage: a difference
// stage, a squaring stage, a sum stage, a square root of COORD_WIDTH+2 bit
// stages, a residual stage, a divider of 32 bit stages (both gradient ratios
// side by side), and an output register. Throughput is one word per cycle.
// When m_axis_tready is low with a result waiting, the whole pipeline holds;
// s_axis_tready is high whenever the output register is empty or being taken,
// so no bubble is needed.
// Synchronous active-low reset clears all valid bits; no word is held.
// A missing point gives zero numbers with status 2; coincident points give
// the target as residual, zero gradient and status 1.
module point_distance_residual_gradient #(
    parameter int COORD_WIDTH = pdrg_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // first_x, first_y, second_x, second_y, target_distance (low bit up)
    input  logic [((4*COORD_WIDTH+32+7)/8)*8-1:0] s_axis_tdata,
    // points_present
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // residual, grad_first_x, grad_first_y, grad_second_x, grad_second_y
    output logic [159:0]                  m_axis_tdata,
    // status
    output logic [1:0]                    m_axis_tuser
);
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;        // difference magnitude width
    localparam int SQW   = 2 * DW;
    localparam int RADW  = SQW + 1;
    localparam int ROOTW = RADW / 2 + 1;
    localparam int TW    = pdrg_pkg::TARGET_WIDTH;
    localparam int GW    = pdrg_pkg::GRAD_WIDTH;
    localparam int SIDE1 = TW + 3;        // target, present, negx, negy

    logic en;
    logic out_full_reg;
    assign en            = !out_full_reg || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: differences and magnitudes
    logic signed [CW-1:0] fx, fy, sx, sy;
    logic signed [CW:0]   dx, dy;
    assign fx = s_axis_tdata[0*CW +: CW];
    assign fy = s_axis_tdata[1*CW +: CW];
    assign sx = s_axis_tdata[2*CW +: CW];
    assign sy = s_axis_tdata[3*CW +: CW];
    assign dx = DW'(fx) - DW'(sx);
    assign dy = DW'(fy) - DW'(sy);

    logic            v1_reg;
    logic [DW-1:0]   ax_reg, ay_reg;
    logic            nx1_reg, ny1_reg, p1_reg;
    logic [TW-1:0]   t1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_axis_tvalid;
        end
        if (en) begin
            ax_reg  <= dx[CW] ? DW'(-dx) : DW'(dx);
            ay_reg  <= dy[CW] ? DW'(-dy) : DW'(dy);
            nx1_reg <= dx[CW];
            ny1_reg <= dy[CW];
            p1_reg  <= s_axis_tuser;
            t1_reg  <= s_axis_tdata[4*CW +: TW];
        end
    end

    // stage 2: squares
    logic            v2_reg, nx2_reg, ny2_reg, p2_reg;
    logic [SQW-1:0]  sqx_reg, sqy_reg;
    logic [DW-1:0]   ax2_reg, ay2_reg;
    logic [TW-1:0]   t2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            sqx_reg <= SQW'(ax_reg) * SQW'(ax_reg);
            sqy_reg <= SQW'(ay_reg) * SQW'(ay_reg);
            ax2_reg <= ax_reg;
            ay2_reg <= ay_reg;
            nx2_reg <= nx1_reg;
            ny2_reg <= ny1_reg;
            p2_reg  <= p1_reg;
            t2_reg  <= t1_reg;
        end
    end

    // stage 3: sum of squares
    logic            v3_reg;
    logic [RADW-1:0] rad_reg;
    logic [SIDE1-1:0] side3_reg;
    logic [2*DW-1:0] axy3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            rad_reg   <= RADW'(sqx_reg) + RADW'(sqy_reg);
            side3_reg <= {t2_reg, p2_reg, nx2_reg, ny2_reg};
            axy3_reg  <= {ax2_reg, ay2_reg};
        end
    end

    // square root; magnitudes ride along in the sideband
    logic                     vs;
    logic [ROOTW-1:0]         root;
    logic [SIDE1+2*DW-1:0]    sides;
    pdrg_sqrt #(.RAD_W(RADW), .SIDE_W(SIDE1 + 2*DW)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v3_reg),
        .in_rad   (rad_reg),
        .in_side  ({side3_reg, axy3_reg}),
        .out_valid(vs),
        .out_root (root),
        .out_side (sides)
    );

    // residual stage
    logic [TW-1:0] tgt;
    logic          pres, snx, sny, up;
    logic [ROOTW:0] diff;
    assign {tgt, pres, snx, sny} = sides[2*DW +: SIDE1];
    assign up   = root >= ROOTW'(tgt);
    assign diff = up ? (ROOTW+1)'(root) - (ROOTW+1)'(tgt)
                     : (ROOTW+1)'(tgt) - (ROOTW+1)'(root);

    localparam int DDW = ROOTW;
    logic            v4_reg;
    logic [TW-1:0]   res4_reg;
    logic [DDW-1:0]  d4_reg;
    logic [DW-1:0]   ax4_reg, ay4_reg;
    logic [3:0]      fl4_reg;   // present, zero, negx, negy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= vs;
        end
        if (en) begin
            res4_reg <= (diff > (ROOTW+1)'({TW{1'b1}})) ? {TW{1'b1}} : TW'(diff);
            d4_reg   <= root;
            ax4_reg  <= sides[DW +: DW];
            ay4_reg  <= sides[0 +: DW];
            fl4_reg  <= {pres, root == '0, snx == up, sny == up};
        end
    end

    logic            vd;
    logic [GW-1:0]   gx, gy;
    logic [TW+3:0]   sd;
    pdrg_div #(.D_W(DDW), .SIDE_W(TW + 4)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v4_reg),
        .in_d     (d4_reg),
        .in_ax    (DDW'(ax4_reg)),
        .in_ay    (DDW'(ay4_reg)),
        .in_side  ({res4_reg, fl4_reg}),
        .out_valid(vd),
        .out_gx   (gx),
        .out_gy   (gy),
        .out_side (sd)
    );

    // output register
    pdrg_pkg::result_t res_next, res_reg;
    always_comb begin
        res_next = '0;
        if (!sd[3]) begin
            res_next.status = pdrg_pkg::STATUS_MISSING;
        end else if (sd[2]) begin
            res_next.residual = sd[TW+3:4];
            res_next.status   = pdrg_pkg::STATUS_COINCIDENT;
        end else begin
            res_next.residual      = sd[TW+3:4];
            res_next.grad_first_x  = sd[1] ? -gx : gx;
            res_next.grad_first_y  = sd[0] ? -gy : gy;
            res_next.grad_second_x = sd[1] ? gx : -gx;
            res_next.grad_second_y = sd[0] ? gy : -gy;
            res_next.status        = pdrg_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_full_reg <= 1'b0;
        end else if (en) begin
            out_full_reg <= vd;
        end
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_full_reg;
    assign m_axis_tdata  = {res_reg.grad_second_y, res_reg.grad_second_x,
                            res_reg.grad_first_y, res_reg.grad_first_x, res_reg.residual};
    assign m_axis_tuser  = res_reg.status;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output state");
    a_missing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == pdrg_pkg::STATUS_MISSING |-> m_axis_tdata == '0)
        else $error("missing point gave nonzero numbers");
    a_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[159:128] == -m_axis_tdata[95:64])
        else $error("second gradient not negated first");
endmodule

/* hdl/pdrg_sqrt.sv */
// Pipelined restoring square root, one result bit per stage, rounded half up.
// Sideband of SIDE_W bits travels with each word.
module pdrg_sqrt #(
    parameter int RAD_W  = 66,
    parameter int SIDE_W = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [RAD_W-1:0]      in_rad,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [RAD_W/2:0]      out_root,
    output logic [SIDE_W-1:0]     out_side
);
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int PAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic [PAD_W-1:0]  rad_reg  [ROOT_W+1];
    logic [REM_W-1:0]  rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] root_reg [ROOT_W+1];
    logic [SIDE_W-1:0] side_reg [ROOT_W+1];
    logic [ROOT_W:0]   vld_reg;

    always_comb begin
        rad_reg[0]  = PAD_W'(in_rad);
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        side_reg[0] = in_side;
        vld_reg[0]  = in_valid;
    end

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] sub;
        logic             fits;
        always_comb begin
            trial = {rem_reg[s][REM_W-3:0], rad_reg[s][PAD_W-1 -: 2]};
            sub   = {root_reg[s], 2'b01};
            fits  = trial >= sub;
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s+1] <= 1'b0;
            end else if (en) begin
                vld_reg[s+1] <= vld_reg[s];
            end
            if (en) begin
                rad_reg[s+1]  <= rad_reg[s] << 2;
                rem_reg[s+1]  <= fits ? trial - sub : trial;
                root_reg[s+1] <= {root_reg[s][ROOT_W-2:0], fits};
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    // remainder above root means the exact root is past the half point
    assign out_valid = vld_reg[ROOT_W];
    assign out_root  = (RAD_W/2 + 1)'(root_reg[ROOT_W])
                     + (RAD_W/2 + 1)'(rem_reg[ROOT_W] > REM_W'(root_reg[ROOT_W]));
    assign out_side  = side_reg[ROOT_W];
endmodule

/* hdl/pdrg_div.sv */
// Pipelined restoring divider for two ratios a/d with a <= d, one quotient bit per stage.
module pdrg_div #(
    parameter int D_W    = 34,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [D_W-1:0]    in_d,
    input  logic [D_W-1:0]    in_ax,
    input  logic [D_W-1:0]    in_ay,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [pdrg_pkg::GRAD_WIDTH-1:0] out_gx,
    output logic [pdrg_pkg::GRAD_WIDTH-1:0] out_gy,
    output logic [SIDE_W-1:0] out_side
);
    localparam int N   = pdrg_pkg::QUO_BITS;
    localparam int R_W = D_W + 1;

    logic [D_W-1:0]    d_reg  [N+1];
    logic [R_W-1:0]    rx_reg [N+1];
    logic [R_W-1:0]    ry_reg [N+1];
    logic [N-1:0]      qx_reg [N+1];
    logic [N-1:0]      qy_reg [N+1];
    logic [SIDE_W-1:0] side_reg [N+1];
    logic [N:0]        vld_reg;

    always_comb begin
        d_reg[0]    = in_d;
        rx_reg[0]   = R_W'(in_ax);
        ry_reg[0]   = R_W'(in_ay);
        qx_reg[0]   = '0;
        qy_reg[0]   = '0;
        side_reg[0] = in_side;
        vld_reg[0]  = in_valid;
    end

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic fx, fy;
        logic [R_W-1:0] nx, ny;
        always_comb begin
            fx = rx_reg[s] >= R_W'(d_reg[s]);
            fy = ry_reg[s] >= R_W'(d_reg[s]);
            nx = fx ? rx_reg[s] - R_W'(d_reg[s]) : rx_reg[s];
            ny = fy ? ry_reg[s] - R_W'(d_reg[s]) : ry_reg[s];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s+1] <= 1'b0;
            end else if (en) begin
                vld_reg[s+1] <= vld_reg[s];
            end
            if (en) begin
                d_reg[s+1]    <= d_reg[s];
                rx_reg[s+1]   <= {nx[R_W-2:0], 1'b0};
                ry_reg[s+1]   <= {ny[R_W-2:0], 1'b0};
                qx_reg[s+1]   <= {qx_reg[s][N-2:0], fx};
                qy_reg[s+1]   <= {qy_reg[s][N-2:0], fy};
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    logic [N:0] rndx, rndy;
    assign rndx      = (N+1)'(qx_reg[N]) + (N+1)'(1);
    assign rndy      = (N+1)'(qy_reg[N]) + (N+1)'(1);
    assign out_valid = vld_reg[N];
    assign out_gx    = pdrg_pkg::GRAD_WIDTH'(rndx[N:1]);
    assign out_gy    = pdrg_pkg::GRAD_WIDTH'(rndy[N:1]);
    assign out_side  = side_reg[N];
endmodule
